// ===== rtl/ipcs_pkg.sv =====
// types, constants and helper functions shared by the covariance step block
`timescale 1ns / 1ps

package ipcs_pkg;

    localparam int DIM    = 9;
    localparam int IN_W   = 26;
    localparam int NUM_IN = 6;
    localparam int VAL_W  = 48;
    localparam int ACC_W  = 52;
    localparam int OUT_W  = 47;
    localparam int Q_W    = 33;
    localparam int IDX_W  = 4;
    localparam int PH_W   = 3;
    localparam int PROD_W = 96;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
    localparam logic [PH_W-1:0]  PH_LAST  = 3'd5;
    localparam logic signed [VAL_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;

    localparam logic [CIDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CIDX_W-1:0] REG_GYRO_VAR  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ACC_VAR   = 2'd2;

    localparam logic [CFG_W-1:0] TIME_STEP_RST = 32'd21474836;
    localparam logic [CFG_W-1:0] GYRO_VAR_RST  = 32'd429497;
    localparam logic [CFG_W-1:0] ACC_VAR_RST   = 32'd42949673;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef val_t col_t [DIM];
    typedef logic [Q_W-1:0] noise_t;

    // sv: scaled rate x,y,z then scaled acc x,y,z, all Q.32
    typedef struct packed {
        val_t [NUM_IN-1:0] sv;
        logic [CFG_W-1:0]  dt;
    } coef_t;

    typedef struct packed {
        logic             clear_s;
        logic             run;
        logic             pass2;
        logic             acc_clr;
        logic             shift;
        logic             commit_t;
        logic             commit_s;
        logic [PH_W-1:0]  phase;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] k;
    } ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_PASS1,
        ST_COMMIT1,
        ST_PASS2,
        ST_COMMIT2,
        ST_DONE
    } state_t;

    function automatic val_t sat_val(input logic signed [ACC_W-1:0] x);
        val_t r;
        if (x[ACC_W-1:VAL_W-1] == '0 || x[ACC_W-1:VAL_W-1] == '1) begin
            r = x[VAL_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    // entry (r, c) of -skew(v)
    function automatic val_t neg_skew(input logic [1:0] r, input logic [1:0] c,
                                      input val_t vx, input val_t vy, input val_t vz);
        val_t v;
        case ({r, c})
            4'b0001: v = vz;
            4'b0010: v = -vy;
            4'b0100: v = -vz;
            4'b0110: v = vx;
            4'b1000: v = vy;
            4'b1001: v = -vx;
            default: v = '0;
        endcase
        return v;
    endfunction

    // entry (row, col) of the transition matrix
    function automatic val_t a_coef(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                    input coef_t c);
        logic [IDX_W-1:0] rr;
        val_t v;
        rr = row - 4'd3;
        v  = '0;
        if (row == col) begin
            v = ONE_Q32;
        end else if (row < 4'd3 && col < 4'd3) begin
            v = neg_skew(row[1:0], col[1:0], c.sv[0], c.sv[1], c.sv[2]);
        end else if (row >= 4'd3 && row < 4'd6 && col < 4'd3) begin
            v = neg_skew(rr[1:0], col[1:0], c.sv[3], c.sv[4], c.sv[5]);
        end else if (row >= 4'd6 && col == rr) begin
            v = {16'b0, c.dt};
        end
        return v;
    endfunction

endpackage

// ===== rtl/imu_preint_covariance_step.sv =====
// top level: sequencer, configuration registers and the ring of nine cells
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | acc x,y,z, rate x,y,z (26b each), restart in tuser
//  m_      | out | m_tvalid/m_tready  | nine diagonal variances, 47b each
//  cfg_    | in  | cfg_valid/cfg_ready| register index and 32b value
//
// an accepted sample passes through the coefficient unit, then 2 x 81 products per
// cell on the cell's 32x32 multiplier, then the two commits and the output load.
// reset clears the covariance and loads the default time step and noise values.
// the next sample is taken once the previous result sits in the output register;
// a stalled output holds the finished step until the register frees up.
`timescale 1ns / 1ps

module imu_preint_covariance_step import ipcs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [159:0]        s_tdata,   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, pad
    input  logic [0:0]          s_tuser,   // restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [423:0]        m_tdata,   // var_rot_x..z, var_vel_x..z, var_pos_x..z, pad
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, k_reg, k_next;
    logic [PH_W-1:0]  ph_reg, ph_next;
    logic             m_valid_reg, m_valid_next;
    logic [423:0]     m_data_reg, m_data_next;
    logic [CFG_W-1:0] dt_reg, gvar_reg, avar_reg;
    logic signed [IN_W-1:0] in_reg [NUM_IN];
    logic signed [IN_W-1:0] coef_in [NUM_IN];

    logic   in_acc, coef_start, coef_done, out_load;
    ctl_t   ctl;
    coef_t  coef;
    noise_t qg, qa;
    val_t   a_bcast;
    col_t   t_bus [DIM];
    val_t   diag_bus [DIM];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg   <= TIME_STEP_RST;
            gvar_reg <= GYRO_VAR_RST;
            avar_reg <= ACC_VAR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIME_STEP: dt_reg   <= cfg_data;
                REG_GYRO_VAR:  gvar_reg <= cfg_data;
                REG_ACC_VAR:   avar_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int n = 0; n < NUM_IN; n++) begin
                in_reg[n] <= s_tdata[n*IN_W +: IN_W];
            end
        end
    end

    // rate terms first, then acceleration terms
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            coef_in[n]     = in_reg[n+3];
            coef_in[n + 3] = in_reg[n];
        end
    end

    assign coef_start = in_acc;

    ipcs_coef u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (coef_start),
        .vals    (coef_in),
        .dt      (dt_reg),
        .gvar    (gvar_reg),
        .avar    (avar_reg),
        .coef    (coef),
        .qg      (qg),
        .qa      (qa),
        .done    (coef_done)
    );

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                if (coef_done) begin
                    state_next = ST_PASS1;
                    i_next     = '0;
                    k_next     = '0;
                    ph_next    = '0;
                end
            end
            ST_PASS1: begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == PH_LAST) begin
                    ph_next = '0;
                    if (k_reg == LAST_IDX) begin
                        k_next = '0;
                        if (i_reg == LAST_IDX) begin
                            i_next     = '0;
                            state_next = ST_COMMIT1;
                        end else begin
                            i_next = i_reg + 4'd1;
                        end
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            ST_COMMIT1: begin
                state_next = ST_PASS2;
            end
            ST_PASS2: begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == PH_LAST) begin
                    ph_next = '0;
                    if (i_reg == LAST_IDX) begin
                        i_next = '0;
                        if (k_reg == LAST_IDX) begin
                            k_next     = '0;
                            state_next = ST_COMMIT2;
                        end else begin
                            k_next = k_reg + 4'd1;
                        end
                    end else begin
                        i_next = i_reg + 4'd1;
                    end
                end
            end
            ST_COMMIT2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            k_reg       <= '0;
            ph_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            ph_reg      <= ph_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
        m_data_next = m_data_reg;
        if (out_load) begin
            m_data_next = '0;
            for (int n = 0; n < DIM; n++) begin
                // negative variances read as zero
                m_data_next[n*OUT_W +: OUT_W] = diag_bus[n][VAL_W-1] ? '0
                                                                     : diag_bus[n][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        ctl.clear_s  = in_acc && s_tuser[0];
        ctl.run      = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
        ctl.pass2    = (state_reg == ST_PASS2);
        ctl.acc_clr  = ((state_reg == ST_COEF) && coef_done) || (state_reg == ST_COMMIT1);
        ctl.shift    = (state_reg == ST_PASS2) && (ph_reg == PH_LAST) && (i_reg == LAST_IDX);
        ctl.commit_t = (state_reg == ST_COMMIT1);
        ctl.commit_s = (state_reg == ST_COMMIT2);
        ctl.phase    = ph_reg;
        ctl.i        = i_reg;
        ctl.k        = k_reg;
        a_bcast      = a_coef(i_reg, k_reg, coef);
    end

    for (genvar n = 0; n < DIM; n++) begin : g_cell
        ipcs_cell #(
            .CELL_IDX (n)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .a_bcast (a_bcast),
            .coef    (coef),
            .noise   ((n < 3) ? qg : ((n < 6) ? qa : '0)),
            .t_in    (t_bus[(n + 1) % DIM]),
            .t_out   (t_bus[n]),
            .diag    (diag_bus[n])
        );
    end

endmodule

// ===== rtl/ipcs_coef.sv =====
// coefficient unit: scaled skew terms and noise terms over eight multiplies
`timescale 1ns / 1ps

module ipcs_coef import ipcs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [IN_W-1:0] vals [NUM_IN],
    input  logic [CFG_W-1:0]       dt,
    input  logic [CFG_W-1:0]       gvar,
    input  logic [CFG_W-1:0]       avar,
    output coef_t                  coef,
    output noise_t                 qg,
    output noise_t                 qa,
    output logic                   done
);

    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        wr_reg, wr_next;
    logic [2:0]  widx_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    val_t        sv_reg [NUM_IN];
    noise_t      qg_reg, qa_reg;

    logic signed [IN_W-1:0] v_sel;
    logic [IN_W-1:0]        v_mag;
    logic [CFG_W-1:0]       mul_l, mul_r;
    logic [63:0]            rnd16;
    logic [64:0]            rnd32;
    val_t                   scaled;

    always_comb begin
        case (cnt_reg)
            3'd0: v_sel = vals[0];
            3'd1: v_sel = vals[1];
            3'd2: v_sel = vals[2];
            3'd3: v_sel = vals[3];
            3'd4: v_sel = vals[4];
            3'd5: v_sel = vals[5];
            default: v_sel = '0;
        endcase
        v_mag = v_sel[IN_W-1] ? IN_W'(-v_sel) : v_sel;
        case (cnt_reg)
            3'd6: begin
                mul_l = dt;
                mul_r = gvar;
            end
            3'd7: begin
                mul_l = dt;
                mul_r = avar;
            end
            default: begin
                mul_l = CFG_W'(v_mag);
                mul_r = dt;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        wr_next   = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            wr_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            wr_reg   <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_l * mul_r;
        widx_reg <= cnt_reg;
        neg_reg  <= v_sel[IN_W-1];
    end

    // second stage: round the registered product into its slot
    always_comb begin
        rnd16  = prod_reg + 64'h8000;
        rnd32  = {1'b0, prod_reg} + 65'h8000_0000;
        scaled = neg_reg ? -val_t'(rnd16[63:16]) : val_t'(rnd16[63:16]);
    end

    always_ff @(posedge aclk) begin
        if (wr_reg) begin
            case (widx_reg)
                3'd6: qg_reg <= rnd32[64:32];
                3'd7: qa_reg <= rnd32[64:32];
                default: sv_reg[widx_reg] <= scaled;
            endcase
        end
    end

    always_comb begin
        for (int n = 0; n < NUM_IN; n++) begin
            coef.sv[n] = sv_reg[n];
        end
        coef.dt = dt;
    end

    assign qg   = qg_reg;
    assign qa   = qa_reg;
    assign done = wr_reg && (widx_reg == 3'd7);

endmodule

// ===== rtl/ipcs_cell.sv =====
// one cell of the ring: a covariance column, its product column and a multiply-accumulate
`timescale 1ns / 1ps

module ipcs_cell import ipcs_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  ctl_t   ctl,
    input  val_t   a_bcast,
    input  coef_t  coef,
    input  noise_t noise,
    input  col_t   t_in,
    output col_t   t_out,
    output val_t   diag
);

    localparam logic [IDX_W-1:0] ID = IDX_W'(CELL_IDX);

    val_t s_reg [DIM], s_next [DIM];
    val_t t_reg [DIM], t_next [DIM];
    logic signed [ACC_W-1:0] acc_reg [DIM], acc_next [DIM];
    logic [63:0]       pp_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic [IDX_W:0]    k_sum;
    logic [IDX_W-1:0]  k_own;
    val_t              a_own, op_a, op_b;
    logic [VAL_W-1:0]  mag_a, mag_b;
    logic [31:0]       mul_l, mul_r;
    logic [PROD_W-1:0] pp_ext;
    logic              neg;
    logic [PROD_W:0]   rnd;
    logic [PROD_W-32:0] m_full;
    logic [VAL_W:0]    lim, m_sat;
    logic signed [ACC_W-1:0] m_ext, term;

    // after r shifts this cell holds product column (ID + r) mod DIM
    always_comb begin
        k_sum = {1'b0, ID} + {1'b0, ctl.k};
        k_own = (k_sum >= 5'd9) ? 4'(k_sum - 5'd9) : k_sum[IDX_W-1:0];
        a_own = a_coef(ID, k_own, coef);
        op_a  = ctl.pass2 ? a_own : a_bcast;
        op_b  = ctl.pass2 ? t_reg[ctl.i] : s_reg[ctl.k];
        mag_a = op_a[VAL_W-1] ? VAL_W'(-op_a) : op_a;
        mag_b = op_b[VAL_W-1] ? VAL_W'(-op_b) : op_b;
        neg   = op_a[VAL_W-1] ^ op_b[VAL_W-1];
    end

    // four 32x32 partial products, one per phase
    always_comb begin
        case (ctl.phase)
            3'd0: begin
                mul_l = mag_a[31:0];
                mul_r = mag_b[31:0];
            end
            3'd1: begin
                mul_l = mag_a[31:0];
                mul_r = {16'b0, mag_b[VAL_W-1:32]};
            end
            3'd2: begin
                mul_l = {16'b0, mag_a[VAL_W-1:32]};
                mul_r = mag_b[31:0];
            end
            3'd3: begin
                mul_l = {16'b0, mag_a[VAL_W-1:32]};
                mul_r = {16'b0, mag_b[VAL_W-1:32]};
            end
            default: begin
                mul_l = '0;
                mul_r = '0;
            end
        endcase
        case (ctl.phase)
            3'd1: pp_ext = {32'b0, pp_reg};
            3'd2: pp_ext = {pp_reg, 32'b0};
            3'd3: pp_ext = {pp_reg, 32'b0};
            3'd4: pp_ext = {pp_reg[31:0], 64'b0};
            default: pp_ext = '0;
        endcase
        prod_next = (ctl.phase == 3'd0) ? '0 : prod_reg + pp_ext;
    end

    // round magnitude half up, saturate, restore sign
    always_comb begin
        rnd    = {1'b0, prod_reg} + 97'h8000_0000;
        m_full = rnd[PROD_W:32];
        lim    = neg ? {1'b0, 1'b1, {(VAL_W-1){1'b0}}} : {2'b00, {(VAL_W-1){1'b1}}};
        m_sat  = (m_full > lim) ? lim : m_full[VAL_W:0];
        m_ext  = ACC_W'(m_sat);
        term   = neg ? -m_ext : m_ext;
    end

    always_comb begin
        for (int n = 0; n < DIM; n++) begin
            acc_next[n] = acc_reg[n];
            t_next[n]   = t_reg[n];
            s_next[n]   = s_reg[n];
            if (ctl.acc_clr) begin
                acc_next[n] = '0;
            end else if (ctl.run && ctl.phase == PH_LAST && ctl.i == IDX_W'(n)) begin
                acc_next[n] = acc_reg[n] + term;
            end
            if (ctl.commit_t) begin
                t_next[n] = sat_val(acc_reg[n]);
            end else if (ctl.shift) begin
                t_next[n] = t_in[n];
            end
            if (ctl.clear_s) begin
                s_next[n] = '0;
            end else if (ctl.commit_s) begin
                if (n == CELL_IDX) begin
                    s_next[n] = sat_val(ACC_W'(sat_val(acc_reg[n])) + ACC_W'(noise));
                end else begin
                    s_next[n] = sat_val(acc_reg[n]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < DIM; n++) begin
                s_reg[n] <= '0;
            end
        end else begin
            for (int n = 0; n < DIM; n++) begin
                s_reg[n] <= s_next[n];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg   <= mul_l * mul_r;
        prod_reg <= prod_next;
        for (int n = 0; n < DIM; n++) begin
            acc_reg[n] <= acc_next[n];
            t_reg[n]   <= t_next[n];
        end
    end

    always_comb begin
        for (int n = 0; n < DIM; n++) begin
            t_out[n] = t_reg[n];
        end
    end

    assign diag = s_reg[CELL_IDX];

endmodule

// ===== tb/imu_preint_covariance_check.sv =====
// checker: watches the sample, config and result channels and compares diagonals
`timescale 1ns / 1ps

module imu_preint_covariance_check import ipcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [159:0]      s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [423:0]      m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                errors,
    output int                pending
);

    localparam longint LIM_HI = (longint'(1) <<< 47) - 1;
    localparam longint LIM_LO = -(longint'(1) <<< 47);

    longint        cov [DIM][DIM];
    logic [31:0]   dt_reg;
    logic [31:0]   gyro_var_reg;
    logic [31:0]   acc_var_reg;
    logic [423:0]  diag_q [$];
    int            n_results;

    string field_names [DIM] = '{"var_rot_x", "var_rot_y", "var_rot_z",
                                 "var_vel_x", "var_vel_y", "var_vel_z",
                                 "var_pos_x", "var_pos_y", "var_pos_z"};

    assign pending = diag_q.size();

    function automatic longint clamp48(input longint v);
        if (v > LIM_HI) return LIM_HI;
        if (v < LIM_LO) return LIM_LO;
        return v;
    endfunction

    // Q9.16 times Q0.32, magnitude rounded half up to Q.32
    function automatic longint scale_by_dt(input longint s, input logic [31:0] dt);
        logic [63:0] p;
        longint      r;
        p = 64'(s < 0 ? -s : s) * {32'b0, dt};
        r = longint'((p + 64'd32768) >> 16);
        return s < 0 ? -r : r;
    endfunction

    // Q.32 times Q.32, magnitude rounded half up, saturated to 48 bits
    function automatic longint mul_round(input longint a, input longint b);
        logic [127:0] m;
        logic [63:0]  x;
        logic [63:0]  y;
        logic         neg;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        x   = a < 0 ? 64'(-a) : 64'(a);
        y   = b < 0 ? 64'(-b) : 64'(b);
        m   = ({64'b0, x} * {64'b0, y} + 128'h8000_0000) >> 32;
        lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // adds -skew(v)*dt at block (r, c)
    function automatic void add_neg_skew(inout longint a [DIM][DIM], input int r, input int c,
                                         input longint vx, input longint vy, input longint vz,
                                         input logic [31:0] dt);
        a[r][c+1]   += scale_by_dt(vz, dt);
        a[r][c+2]   += scale_by_dt(-vy, dt);
        a[r+1][c]   += scale_by_dt(-vz, dt);
        a[r+1][c+2] += scale_by_dt(vx, dt);
        a[r+2][c]   += scale_by_dt(vy, dt);
        a[r+2][c+1] += scale_by_dt(-vx, dt);
    endfunction

    function automatic logic [423:0] propagate(input logic [159:0] smp, input logic clr);
        longint       a [DIM][DIM];
        longint       t [DIM][DIM];
        longint       v [6];
        longint       s;
        longint       qg;
        longint       qa;
        logic [423:0] res;
        if (clr) begin
            foreach (cov[i, j]) cov[i][j] = 0;
        end
        for (int f = 0; f < 6; f++) v[f] = longint'($signed(smp[26*f +: 26]));
        foreach (a[i, j]) a[i][j] = (i == j) ? (longint'(1) <<< 32) : 0;
        add_neg_skew(a, 0, 0, v[3], v[4], v[5], dt_reg);
        add_neg_skew(a, 3, 0, v[0], v[1], v[2], dt_reg);
        for (int i = 0; i < 3; i++) a[6+i][3+i] = longint'({32'b0, dt_reg});
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                s = 0;
                for (int k = 0; k < DIM; k++) s += mul_round(a[i][k], cov[k][j]);
                t[i][j] = clamp48(s);
            end
        end
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                s = 0;
                for (int k = 0; k < DIM; k++) s += mul_round(t[i][k], a[j][k]);
                cov[i][j] = clamp48(s);
            end
        end
        qg = longint'(({32'b0, dt_reg} * {32'b0, gyro_var_reg} + 64'h8000_0000) >> 32);
        qa = longint'(({32'b0, dt_reg} * {32'b0, acc_var_reg} + 64'h8000_0000) >> 32);
        for (int i = 0; i < 3; i++) begin
            cov[i][i]     = clamp48(cov[i][i] + qg);
            cov[3+i][3+i] = clamp48(cov[3+i][3+i] + qa);
        end
        res = '0;
        for (int i = 0; i < DIM; i++) begin
            // negative diagonal reads as zero, the stored entry keeps its sign
            res[47*i +: 47] = cov[i][i] < 0 ? 47'd0 : cov[i][i][46:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    initial begin
        errors    = 0;
        n_results = 0;
    end

    always @(posedge aclk) begin
        logic [423:0] want;
        if (!aresetn) begin
            foreach (cov[i, j]) cov[i][j] = 0;
            dt_reg       = TIME_STEP_RST;
            gyro_var_reg = GYRO_VAR_RST;
            acc_var_reg  = ACC_VAR_RST;
            diag_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TIME_STEP: dt_reg       = cfg_data;
                    REG_GYRO_VAR:  gyro_var_reg = cfg_data;
                    REG_ACC_VAR:   acc_var_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) diag_q.push_back(propagate(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready) begin
                if (diag_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no sample waiting", n_results));
                end else begin
                    want = diag_q.pop_front();
                    for (int i = 0; i < DIM; i++) begin
                        if (m_tdata[47*i +: 47] !== want[47*i +: 47]) begin
                            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                n_results, field_names[i], m_tdata[47*i +: 47],
                                want[47*i +: 47]));
                        end
                    end
                end
                n_results++;
            end
        end
    end

endmodule

// ===== tb/imu_preint_covariance_step_test.sv =====
// testbench top: clock, reset, sample and config stimulus, verdict
`timescale 1ns / 1ps

module imu_preint_covariance_step_test;
    import ipcs_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [25:0] F_MAX = 26'h1FF_FFFF;
    localparam logic [25:0] F_MIN = 26'h200_0000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [159:0]       s_tdata = '0;   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, pad
    logic [0:0]         s_tuser = '0;   // restart
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [423:0]       m_tdata;        // var_rot_x..z, var_vel_x..z, var_pos_x..z, pad
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    int                 errors;
    int                 pending;
    int                 quiet_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    imu_preint_covariance_step dut (.*);

    imu_preint_covariance_check checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 84 : (mode == IDLE_BOTH) ? 15 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 84 : (mode == IDLE_BOTH) ? 15 : 0;
    endtask

    task automatic send_sample(input logic [25:0] ax, input logic [25:0] ay,
                               input logic [25:0] az, input logic [25:0] rx,
                               input logic [25:0] ry, input logic [25:0] rz,
                               input logic clr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, rz, ry, rx, az, ay, ax};
        s_tuser  <= clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [31:0] dt, input logic [31:0] gv,
                            input logic [31:0] av);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_GYRO_VAR, gv);
        write_reg(REG_ACC_VAR, av);
    endtask

    function automatic logic [25:0] pick_field(input int shape, input int span);
        int mag;
        case (shape)
            0: begin
                mag = $urandom_range(span);
                return ($urandom_range(1) != 0) ? 26'(-mag) : 26'(mag);
            end
            1: return 26'($urandom);
            default: return ($urandom_range(1) != 0) ? F_MAX : F_MIN;
        endcase
    endfunction

    // mostly plausible motion, some full-range noise and extremes
    task automatic random_samples(input int count);
        int shape;
        for (int n = 0; n < count; n++) begin
            shape = ($urandom_range(99) < 70) ? 0 : ($urandom_range(99) < 75) ? 1 : 2;
            send_sample(pick_field(shape, 20 << 16), pick_field(shape, 20 << 16),
                        pick_field(shape, 20 << 16), pick_field(shape, 4 << 16),
                        pick_field(shape, 4 << 16), pick_field(shape, 4 << 16),
                        $urandom_range(99) < 8);
        end
    endtask

    initial begin
        logic [31:0] dt;
        set_idle(IDLE_NONE);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: zero motion, gentle motion, restart, extremes
        send_sample('0, '0, '0, '0, '0, '0, 1'b0);
        send_sample(26'd65536, '0, 26'(-65536), '0, 26'd6554, '0, 1'b0);
        send_sample(26'd65536, 26'd131072, 26'd642252, 26'd3277, 26'(-3277), 26'd1000, 1'b0);
        send_sample('0, '0, '0, '0, '0, '0, 1'b1);
        send_sample(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, 1'b0);
        send_sample(F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, 1'b1);
        drain();

        // zero time step: transition is identity, no noise; ignored index too
        set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, 1'b0);
        send_sample(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, 1'b1);
        drain();

        // largest step and noise: growth into saturation, possible negative diagonals
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample('0, '0, '0, '0, '0, '0, 1'b1);
        for (int n = 0; n < 6; n++) begin
            send_sample(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, 1'b0);
        end
        send_sample(26'd1, 26'(-1), 26'd1, 26'(-1), 26'd1, 26'(-1), 1'b0);
        send_sample(26'd65536, '0, '0, '0, '0, 26'd65536, 1'b1);
        drain();

        set_regs(32'd1, 32'd0, 32'd0);
        send_sample(F_MAX, F_MAX, F_MIN, F_MIN, F_MAX, F_MIN, 1'b0);
        send_sample(26'd3, 26'(-3), 26'd1, 26'd1, 26'(-1), 26'd2, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_idle(idle_mode_t'(ph % 4));
            dt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000, 32'h0010_0000);
            set_regs(dt, $urandom_range(99) < 50 ? $urandom : $urandom_range(1 << 24),
                     $urandom_range(99) < 50 ? $urandom : $urandom_range(1 << 28));
            random_samples(35);
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ipcs_pkg.sv
rtl/ipcs_coef.sv
rtl/ipcs_cell.sv
rtl/imu_preint_covariance_step.sv
tb/imu_preint_covariance_check.sv
tb/imu_preint_covariance_step_test.sv
